// ===== design/flm_pkg.sv =====
// ----------------------------------------------------------------------------
// flm_pkg: shared types and constants for the FIFO-fair lock manager
// Result status codes, request modes and the result record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package flm_pkg;

  localparam int IdPortW  = 8;
  localparam int StatusW  = 3;

  // request mode of an input item
  localparam logic MODE_ACQUIRE = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  typedef enum logic [StatusW-1:0] {
    ST_GRANTED      = 3'd0,
    ST_QUEUED       = 3'd1,
    ST_FREED        = 3'd2,
    ST_HANDOFF      = 3'd3,
    ST_FULL         = 3'd4,
    ST_FREE_RELEASE = 3'd5
  } status_t;

  typedef struct packed {
    status_t              status;
    logic                 grant_valid;
    logic [IdPortW-1:0]   grant_id;
  } flm_result_t;

endpackage

// ===== design/flm_if.sv =====
// ----------------------------------------------------------------------------
// flm_if: valid/ready channels of the lock manager
// Request channel (mode, requester id) and result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface flm_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] requester_id;

  modport source (output valid, output mode, output requester_id, input ready);
  modport sink   (input valid, input mode, input requester_id, output ready);
endinterface

interface flm_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic       grant_valid;
  logic [7:0] grant_id;

  modport source (output valid, output status, output grant_valid, output grant_id,
                  input ready);
  modport sink   (input valid, input status, input grant_valid, input grant_id,
                  output ready);
endinterface

// ===== design/flm_ram.sv =====
// ----------------------------------------------------------------------------
// flm_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module flm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, and read of the old contents
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/flm_core.sv =====
// ----------------------------------------------------------------------------
// flm_core: lock state and waiter queue
// Decides each request combinationally; keeps the oldest waiter prefetched
// from the waiter RAM so a handoff need not wait for a RAM read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module flm_core import flm_pkg::*; #(
  parameter int QUEUE_DEPTH = 32,
  parameter int ID_BITS     = 8,
  localparam int PtrW       = $clog2(QUEUE_DEPTH),
  localparam int CntW       = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  logic               mode,
  input  logic [IdPortW-1:0] req_id,
  output flm_result_t        result,
  output logic               ram_wr_en,
  output logic [PtrW-1:0]    ram_wr_addr,
  output logic [ID_BITS-1:0] ram_wr_data,
  output logic [PtrW-1:0]    ram_rd_addr,
  input  logic [ID_BITS-1:0] ram_rd_data
);

  localparam int ExtW = (ID_BITS > IdPortW) ? ID_BITS : IdPortW;

  logic               held_r, held_nxt;
  logic [PtrW-1:0]    head_r, head_nxt;
  logic [PtrW-1:0]    tail_r, tail_nxt;
  logic [CntW-1:0]    count_r, count_nxt;
  logic               byp_v_r, byp_v_nxt;
  logic [ID_BITS-1:0] byp_d_r;
  logic [ExtW-1:0]    id_ext;
  logic [ID_BITS-1:0] id_st;
  logic [ID_BITS-1:0] head_id;
  logic [ExtW-1:0]    head_ext;
  logic [ExtW-1:0]    req_ext;

  function automatic logic [PtrW-1:0] next_slot(input logic [PtrW-1:0] p);
    if (p == PtrW'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  // id kept in ID_BITS bits
  assign id_ext   = ExtW'(req_id);
  assign id_st    = id_ext[ID_BITS-1:0];
  assign req_ext  = ExtW'(id_st);

  // oldest waiter: RAM prefetch, or the entry written at the head last cycle
  assign head_id  = byp_v_r ? byp_d_r : ram_rd_data;
  assign head_ext = ExtW'(head_id);

  // request decision
  always_comb begin
    held_nxt           = held_r;
    head_nxt           = head_r;
    tail_nxt           = tail_r;
    count_nxt          = count_r;
    ram_wr_en          = 1'b0;
    result.status      = ST_FREE_RELEASE;
    result.grant_valid = 1'b0;
    result.grant_id    = '0;
    if (mode == MODE_ACQUIRE) begin
      if (!held_r) begin
        held_nxt           = fire;
        result.status      = ST_GRANTED;
        result.grant_valid = 1'b1;
        result.grant_id    = req_ext[IdPortW-1:0];
      end else if (count_r == CntW'(QUEUE_DEPTH)) begin
        result.status = ST_FULL;
      end else begin
        ram_wr_en     = fire;
        result.status = ST_QUEUED;
        if (fire) begin
          tail_nxt  = next_slot(tail_r);
          count_nxt = count_r + 1'b1;
        end
      end
    end else begin
      if (!held_r) begin
        result.status = ST_FREE_RELEASE;
      end else if (count_r != '0) begin
        result.status      = ST_HANDOFF;
        result.grant_valid = 1'b1;
        result.grant_id    = head_ext[IdPortW-1:0];
        if (fire) begin
          head_nxt  = next_slot(head_r);
          count_nxt = count_r - 1'b1;
        end
      end else begin
        result.status = ST_FREED;
        if (fire) begin
          held_nxt = 1'b0;
        end
      end
    end
  end

  // RAM: push at tail, keep reading the next head
  assign ram_wr_addr = tail_r;
  assign ram_wr_data = id_st;
  assign ram_rd_addr = head_nxt;
  assign byp_v_nxt   = ram_wr_en && (tail_r == head_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= 1'b0;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      byp_v_r <= 1'b0;
    end else begin
      held_r  <= held_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      byp_v_r <= byp_v_nxt;
    end
    byp_d_r <= id_st;
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(QUEUE_DEPTH))
    else $error("waiter count above queue depth");

  a_waiters_need_holder: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> held_r)
    else $error("waiters queued on a free lock");

  a_queue_push: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && result.status == ST_QUEUED) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queued item did not grow the waiter count");

  a_handoff_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && result.status == ST_HANDOFF) |=>
      (count_r == $past(count_r) - 1'b1) && held_r)
    else $error("handoff did not pop a waiter");
`endif

endmodule

// ===== design/fifo_fair_lock_manager_unit.sv =====
// ----------------------------------------------------------------------------
// fifo_fair_lock_manager_unit: FIFO-fair lock with a waiter queue
// An accepted item is decided in the input register; its result is held in
// the result register until taken. Throughput: 1 item per cycle while the
// output is not stalled; the lock state and the waiter RAM read port each
// update once per cycle, with the oldest waiter prefetched.
// Reset (rst_n low, synchronous): lock free, queue empty; the waiter RAM
// is not cleared, and no entry is read before it is written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fifo_fair_lock_manager_unit import flm_pkg::*; #(
  parameter int QUEUE_DEPTH = 32,
  parameter int ID_BITS     = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  flm_in_if.sink    in_ch,
  flm_out_if.source out_ch
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);

  logic               item_v_r;
  logic               mode_r;
  logic [IdPortW-1:0] id_r;
  logic               out_v_r;
  flm_result_t        res_r;
  flm_result_t        res;
  logic               fire;
  logic               ram_wr_en;
  logic [PtrW-1:0]    ram_wr_addr;
  logic [ID_BITS-1:0] ram_wr_data;
  logic [PtrW-1:0]    ram_rd_addr;
  logic [ID_BITS-1:0] ram_rd_data;

  // an item in the input register is decided when the result register frees
  assign fire        = item_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !item_v_r || fire;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      item_v_r <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) begin
      mode_r <= in_ch.mode;
      id_r   <= in_ch.requester_id;
    end
  end

  flm_core #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .mode        (mode_r),
    .req_id      (id_r),
    .result      (res),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  flm_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_waiters (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fire) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.status      = res_r.status;
  assign out_ch.grant_valid = res_r.grant_valid;
  assign out_ch.grant_id    = res_r.grant_id;

endmodule
